/* hw/rtl/rhc_pkg.sv */
package rhc_pkg;

    localparam int CH_BITS   = 16;
    localparam int HUE_W     = 15;
    localparam int SCALE_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int RAMP_W    = 12;

    localparam logic [CH_BITS-1:0] CH_MAX = '1;

    localparam logic [HUE_W-1:0] HUE_FULL       = 15'd23040;
    localparam logic [HUE_W-1:0] HUE_SIXTH      = 15'd3840;
    localparam logic [HUE_W-1:0] HUE_THIRD      = 15'd7680;
    localparam logic [HUE_W-1:0] HUE_HALF       = 15'd11520;
    localparam logic [HUE_W-1:0] HUE_TWO_THIRDS = 15'd15360;

    localparam logic [1:0] MODE_RGB2HSL = 2'd0;
    localparam logic [1:0] MODE_HSL2RGB = 2'd1;
    localparam logic [1:0] MODE_SCALE   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_SCALE = 2'd1;

    localparam logic [SCALE_W-1:0] LIGHT_SCALE_RESET = 16'd256;

    // divider quotient width covers both saturation and hue offset
    localparam int DIV_QW  = (CH_BITS > HUE_W) ? CH_BITS : HUE_W;
    localparam int INV_LAT = 9;

    typedef enum logic [1:0] {
        RAMP_RISE,
        RAMP_HIGH,
        RAMP_FALL,
        RAMP_LOW
    } t_ramp;

    typedef struct packed {
        logic [CH_BITS-1:0] red;
        logic [CH_BITS-1:0] green;
        logic [CH_BITS-1:0] blue;
        logic [HUE_W-1:0]   hue;
        logic [CH_BITS-1:0] sat;
        logic [CH_BITS-1:0] light;
        logic [CH_BITS-1:0] alpha;
    } t_pix;

endpackage

/* hw/rtl/rhc_delay.sv */
module rhc_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_pipe [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) r_pipe[k] <= '0;
        end else if (i_en) begin
            r_pipe[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) r_pipe[k] <= r_pipe[k-1];
        end
    end

    assign o_data = r_pipe[DEPTH-1];

endmodule

/* hw/rtl/rhc_div.sv */
// Restoring divider, one quotient bit per stage.
// Quotient must fit Q_W bits (num < den << Q_W).
module rhc_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 17,
    parameter int Q_W   = 16
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo
);

    localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [W-1:0]     r_rem [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];
    logic [Q_W-1:0]   r_quo [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        localparam int B = Q_W - 1 - k;
        logic [W-1:0]     w_rem_in;
        logic [W-1:0]     w_sh;
        logic [DEN_W-1:0] w_den_in;
        logic [Q_W-1:0]   w_quo_in;
        logic [W-1:0]     n_rem;
        logic [Q_W-1:0]   n_quo;

        if (k == 0) begin : g_first
            assign w_rem_in = W'(i_num);
            assign w_den_in = i_den;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_den_in = r_den[k-1];
            assign w_quo_in = r_quo[k-1];
        end

        always_comb begin
            w_sh  = W'(w_den_in) << B;
            n_rem = w_rem_in;
            n_quo = w_quo_in;
            if (w_rem_in >= w_sh) begin
                n_rem    = w_rem_in - w_sh;
                n_quo[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_den[k] <= w_den_in;
                r_quo[k] <= n_quo;
            end
        end
    end

    assign o_quo = r_quo[Q_W-1];

endmodule

/* hw/rtl/rhc_inv.sv */
// HSL to RGB, nine register stages.
module rhc_inv
    import rhc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [HUE_W-1:0]   i_hue,
    input  logic [CH_BITS-1:0] i_sat,
    input  logic [CH_BITS-1:0] i_light,
    output logic [CH_BITS-1:0] o_red,
    output logic [CH_BITS-1:0] o_green,
    output logic [CH_BITS-1:0] o_blue
);

    localparam int P_W  = 2 * CH_BITS;
    localparam int X_W  = 2 * CH_BITS + 1;
    localparam int QE_W = CH_BITS + 2;
    localparam int QM_W = X_W + 2;
    localparam int V_W  = CH_BITS + 3;
    localparam int M_W  = CH_BITS + 1;
    localparam int PR_W = M_W + RAMP_W;
    localparam int Y_W  = PR_W + 1;
    localparam int Z_W  = Y_W - 8;
    localparam logic [Z_W-1:0] R15 = Z_W'((64'd1 << Z_W) / 64'd15);

    typedef struct packed {
        logic signed [V_W-1:0] v1;
        logic signed [V_W-1:0] v2;
        logic                  neg;
        t_ramp [2:0]           region;
        logic                  zero;
        logic [CH_BITS-1:0]    light;
    } t_ctl;

    // stage 1
    logic [P_W-1:0]     r1_p;
    logic [HUE_W-1:0]   r1_h;
    logic [CH_BITS-1:0] r1_s, r1_l;
    logic               r1_lo, r1_zero;
    // stage 2
    logic [X_W-1:0]     r2_x;
    logic [QE_W-1:0]    r2_qe;
    logic [HUE_W-1:0]   r2_h;
    logic [CH_BITS-1:0] r2_s, r2_l;
    logic               r2_lo, r2_zero;
    // stage 3
    logic [CH_BITS-1:0] r3_ls;
    logic [HUE_W-1:0]   r3_h;
    logic [CH_BITS-1:0] r3_s, r3_l;
    logic               r3_lo, r3_zero;
    // stage 4
    logic signed [V_W-1:0] r4_v1, r4_v2;
    logic [HUE_W-1:0]      r4_t [3];
    logic                  r4_zero;
    logic [CH_BITS-1:0]    r4_l;
    // stages 5 to 8
    logic [M_W-1:0]    r5_mag;
    logic [RAMP_W-1:0] r5_x [3];
    t_ctl              r5_ctl, r6_ctl, r7_ctl, r8_ctl;
    logic [PR_W-1:0]   r6_prod [3];
    logic [Z_W-1:0]    r7_z [3];
    logic [Z_W-1:0]    r7_qe [3];
    logic [Z_W-1:0]    r8_q [3];
    // stage 9
    logic [CH_BITS-1:0] r9_ch [3];

    // stage 1: l * s
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p    <= P_W'(i_light) * P_W'(i_sat);
            r1_h    <= i_hue;
            r1_s    <= i_sat;
            r1_l    <= i_light;
            r1_lo   <= {i_light, 1'b0} < {1'b0, CH_MAX};
            r1_zero <= (i_sat == '0);
        end
    end

    // stage 2: estimate of rounded p / M, within one
    logic [X_W-1:0] w_x;
    logic [X_W:0]   w_xs;
    always_comb begin
        w_x  = X_W'(r1_p) + X_W'(CH_MAX >> 1);
        w_xs = {1'b0, w_x} + (X_W+1)'(w_x >> CH_BITS) + (X_W+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_x    <= w_x;
            r2_qe   <= w_xs[X_W:CH_BITS];
            r2_h    <= r1_h;
            r2_s    <= r1_s;
            r2_l    <= r1_l;
            r2_lo   <= r1_lo;
            r2_zero <= r1_zero;
        end
    end

    // stage 3: correct the estimate
    logic [QM_W-1:0]        w_qm;
    logic signed [QM_W:0]   w_rem;
    logic [QE_W-1:0]        w_ls;
    always_comb begin
        w_qm  = QM_W'(r2_qe) * QM_W'(CH_MAX);
        w_rem = $signed({1'b0, QM_W'(r2_x)}) - $signed({1'b0, w_qm});
        if (w_rem < 0)
            w_ls = r2_qe - QE_W'(1);
        else if (w_rem >= $signed((QM_W+1)'(CH_MAX)))
            w_ls = r2_qe + QE_W'(1);
        else
            w_ls = r2_qe;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_ls   <= w_ls[CH_BITS-1:0];
            r3_h    <= r2_h;
            r3_s    <= r2_s;
            r3_l    <= r2_l;
            r3_lo   <= r2_lo;
            r3_zero <= r2_zero;
        end
    end

    // stage 4: v1, v2 and per-channel hue positions
    logic signed [V_W-1:0] w_v1, w_v2, w_l, w_s, w_ls_s;
    logic [HUE_W:0]        w_tr;
    logic [HUE_W-1:0]      w_tb;
    always_comb begin
        w_l    = $signed(V_W'(r3_l));
        w_s    = $signed(V_W'(r3_s));
        w_ls_s = $signed(V_W'(r3_ls));
        w_v2   = r3_lo ? (w_l + w_ls_s) : (w_l + w_s - w_ls_s);
        w_v1   = (w_l <<< 1) - w_v2;
        w_tr   = {1'b0, r3_h} + {1'b0, HUE_THIRD};
        if (w_tr >= {1'b0, HUE_FULL}) w_tr = w_tr - {1'b0, HUE_FULL};
        w_tb   = (r3_h >= HUE_THIRD) ? (r3_h - HUE_THIRD) : (r3_h + HUE_TWO_THIRDS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_v1   <= w_v1;
            r4_v2   <= w_v2;
            r4_t[0] <= w_tr[HUE_W-1:0];
            r4_t[1] <= r3_h;
            r4_t[2] <= w_tb;
            r4_zero <= r3_zero;
            r4_l    <= r3_l;
        end
    end

    // stage 5: ramp segment per channel
    logic signed [V_W:0] w_diff;
    logic [V_W:0]        w_dmag;
    t_ramp               w_reg [3];
    logic [RAMP_W-1:0]   w_rx [3];
    logic [HUE_W-1:0]    w_fall [3];
    always_comb begin
        w_diff = $signed({r4_v2[V_W-1], r4_v2}) - $signed({r4_v1[V_W-1], r4_v1});
        w_dmag = (w_diff < 0) ? $unsigned(-w_diff) : $unsigned(w_diff);
        for (int k = 0; k < 3; k++) begin
            w_fall[k] = HUE_TWO_THIRDS - r4_t[k];
            if (r4_t[k] < HUE_SIXTH) begin
                w_reg[k] = RAMP_RISE;
                w_rx[k]  = r4_t[k][RAMP_W-1:0];
            end else if (r4_t[k] < HUE_HALF) begin
                w_reg[k] = RAMP_HIGH;
                w_rx[k]  = '0;
            end else if (r4_t[k] < HUE_TWO_THIRDS) begin
                w_reg[k] = RAMP_FALL;
                w_rx[k]  = w_fall[k][RAMP_W-1:0];
            end else begin
                w_reg[k] = RAMP_LOW;
                w_rx[k]  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_mag           <= w_dmag[M_W-1:0];
            r5_ctl.v1        <= r4_v1;
            r5_ctl.v2        <= r4_v2;
            r5_ctl.neg       <= (w_diff < 0);
            r5_ctl.zero      <= r4_zero;
            r5_ctl.light     <= r4_l;
            for (int k = 0; k < 3; k++) begin
                r5_x[k]          <= w_rx[k];
                r5_ctl.region[k] <= w_reg[k];
            end
        end
    end

    // stage 6: |v2 - v1| * x
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++)
                r6_prod[k] <= PR_W'(r5_mag) * PR_W'(r5_x[k]);
            r6_ctl <= r5_ctl;
        end
    end

    // stage 7: rounded /3840 = /256 then /15 by reciprocal
    logic [Y_W-1:0]   w_y [3];
    logic [2*Z_W-1:0] w_rp [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_y[k]  = Y_W'(r6_prod[k]) + Y_W'(HUE_SIXTH >> 1);
            w_rp[k] = (2*Z_W)'(w_y[k][Y_W-1:8]) * (2*Z_W)'(R15);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r7_z[k]  <= w_y[k][Y_W-1:8];
                r7_qe[k] <= w_rp[k][2*Z_W-1:Z_W];
            end
            r7_ctl <= r6_ctl;
        end
    end

    // stage 8: estimate is at most one short
    logic [Z_W+3:0] w_r15 [3];
    always_comb begin
        for (int k = 0; k < 3; k++)
            w_r15[k] = (Z_W+4)'(r7_z[k]) - (Z_W+4)'(r7_qe[k]) * (Z_W+4)'(15);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++)
                r8_q[k] <= (w_r15[k] >= (Z_W+4)'(15)) ? r7_qe[k] + Z_W'(1) : r7_qe[k];
            r8_ctl <= r7_ctl;
        end
    end

    // stage 9: channel value and clamp
    logic signed [V_W:0] w_val [3];
    logic signed [V_W:0] w_q [3];
    logic [CH_BITS-1:0]  w_ch [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_q[k] = $signed((V_W+1)'(r8_q[k]));
            case (r8_ctl.region[k])
                RAMP_RISE, RAMP_FALL:
                    w_val[k] = r8_ctl.neg ? ($signed({r8_ctl.v1[V_W-1], r8_ctl.v1}) - w_q[k])
                                          : ($signed({r8_ctl.v1[V_W-1], r8_ctl.v1}) + w_q[k]);
                RAMP_HIGH: w_val[k] = $signed({r8_ctl.v2[V_W-1], r8_ctl.v2});
                default:   w_val[k] = $signed({r8_ctl.v1[V_W-1], r8_ctl.v1});
            endcase
            if (r8_ctl.zero)
                w_ch[k] = r8_ctl.light;
            else if (w_val[k] < 0)
                w_ch[k] = '0;
            else if (w_val[k] > $signed((V_W+1)'(CH_MAX)))
                w_ch[k] = CH_MAX;
            else
                w_ch[k] = w_val[k][CH_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) r9_ch[k] <= w_ch[k];
        end
    end

    assign o_red   = r9_ch[0];
    assign o_green = r9_ch[1];
    assign o_blue  = r9_ch[2];

endmodule

/* hw/rtl/rgb_hsl_colour_converter_top.sv */
// RGB/HSL colour converter, fully pipelined.
// Pipeline: 1 front stage, 16 restoring divider stages, 2 HSL stages,
// 9 HSL-to-RGB stages and 1 output register.
// Throughput: one word per cycle; the pipeline holds only while the output
// skid register is full.
// Reset (synchronous, active low) empties the pipeline and sets mode 0, scale 1.0.
module rgb_hsl_colour_converter_top
    import rhc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [CH_BITS-1:0]   i_red_in,
    input  logic [CH_BITS-1:0]   i_green_in,
    input  logic [CH_BITS-1:0]   i_blue_in,
    input  logic [HUE_W-1:0]     i_hue_in,
    input  logic [CH_BITS-1:0]   i_saturation_in,
    input  logic [CH_BITS-1:0]   i_lightness_in,
    input  logic [CH_BITS-1:0]   i_alpha_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [CH_BITS-1:0]   o_red_out,
    output logic [CH_BITS-1:0]   o_green_out,
    output logic [CH_BITS-1:0]   o_blue_out,
    output logic [HUE_W-1:0]     o_hue_out,
    output logic [CH_BITS-1:0]   o_saturation_out,
    output logic [CH_BITS-1:0]   o_lightness_out,
    output logic [CH_BITS-1:0]   o_alpha_out
);

    localparam int N1_W = 2 * CH_BITS;
    localparam int N2_W = CH_BITS + RAMP_W;
    localparam int LP_W = CH_BITS + SCALE_W;

    typedef struct packed {
        logic               valid;
        logic               grey;
        logic               neg;
        logic [HUE_W-1:0]   base;
        logic [CH_BITS-1:0] light;
        logic [HUE_W-1:0]   hin;
        logic [CH_BITS-1:0] sin;
        logic [CH_BITS-1:0] lin;
        logic [CH_BITS-1:0] alpha;
    } t_sb1;

    typedef struct packed {
        logic               valid;
        logic [HUE_W-1:0]   hue;
        logic [CH_BITS-1:0] sat;
        logic [CH_BITS-1:0] light;
        logic [CH_BITS-1:0] alpha;
    } t_sb4;

    logic [1:0]         r_mode;
    logic [SCALE_W-1:0] r_light_scale;
    logic               w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_RGB2HSL;
            r_light_scale <= LIGHT_SCALE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE:        r_mode        <= i_cfg_data[1:0];
                CFG_LIGHT_SCALE: r_light_scale <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- front: max/min, hue numerator, saturation denominator
    logic [CH_BITS-1:0] w_r, w_g, w_b, w_mx, w_mn, w_na, w_nb, w_mag, w_d;
    logic [CH_BITS:0]   w_sum, w_den;
    logic [HUE_W-1:0]   w_base, w_hin;
    logic               w_neg;

    always_comb begin
        w_r  = i_red_in[CH_BITS-1:0];
        w_g  = i_green_in[CH_BITS-1:0];
        w_b  = i_blue_in[CH_BITS-1:0];
        w_mx = w_r;
        if (w_g > w_mx) w_mx = w_g;
        if (w_b > w_mx) w_mx = w_b;
        w_mn = w_r;
        if (w_g < w_mn) w_mn = w_g;
        if (w_b < w_mn) w_mn = w_b;
        // ties favour red, then green
        if (w_r == w_mx) begin
            w_base = '0;
            w_na   = w_g;
            w_nb   = w_b;
        end else if (w_g == w_mx) begin
            w_base = HUE_THIRD;
            w_na   = w_b;
            w_nb   = w_r;
        end else begin
            w_base = HUE_TWO_THIRDS;
            w_na   = w_r;
            w_nb   = w_g;
        end
        w_neg = w_na < w_nb;
        w_mag = w_neg ? (w_nb - w_na) : (w_na - w_nb);
        w_d   = w_mx - w_mn;
        w_sum = {1'b0, w_mx} + {1'b0, w_mn};
        w_den = (w_sum < {1'b0, CH_MAX}) ? w_sum : ({CH_MAX, 1'b0} - w_sum);
        w_hin = (i_hue_in >= HUE_FULL) ? (i_hue_in - HUE_FULL) : i_hue_in;
    end

    logic               r_f1_valid;
    logic [CH_BITS-1:0] r_f1_d, r_f1_mag;
    logic [CH_BITS:0]   r_f1_den;
    t_sb1               r_f1_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_f1_valid <= 1'b0;
        else if (w_en) r_f1_valid <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_d        <= w_d;
            r_f1_mag      <= w_mag;
            r_f1_den      <= w_den;
            r_f1_sb.valid <= i_valid;
            r_f1_sb.grey  <= (w_d == '0);
            r_f1_sb.neg   <= w_neg;
            r_f1_sb.base  <= w_base;
            r_f1_sb.light <= w_sum[CH_BITS:1];
            r_f1_sb.hin   <= w_hin;
            r_f1_sb.sin   <= i_saturation_in[CH_BITS-1:0];
            r_f1_sb.lin   <= i_lightness_in[CH_BITS-1:0];
            r_f1_sb.alpha <= i_alpha_in;
        end
    end

    // ---- dividers: saturation and hue offset, rounded half up
    logic [N1_W-1:0]   w_n1;
    logic [N2_W-1:0]   w_n2;
    logic [DIV_QW-1:0] w_q1, w_q2;
    t_sb1              w_f1_sb, w_sb2;

    always_comb begin
        w_n1          = N1_W'(r_f1_d) * N1_W'(CH_MAX) + N1_W'(r_f1_den >> 1);
        w_n2          = N2_W'(r_f1_mag) * N2_W'(HUE_SIXTH) + N2_W'(r_f1_d >> 1);
        w_f1_sb       = r_f1_sb;
        w_f1_sb.valid = r_f1_valid;
    end

    rhc_div #(.NUM_W(N1_W), .DEN_W(CH_BITS + 1), .Q_W(DIV_QW)) u_div_sat (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_n1),
        .i_den (r_f1_den),
        .o_quo (w_q1)
    );

    rhc_div #(.NUM_W(N2_W), .DEN_W(CH_BITS), .Q_W(DIV_QW)) u_div_hue (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_n2),
        .i_den (r_f1_d),
        .o_quo (w_q2)
    );

    rhc_delay #(.WIDTH($bits(t_sb1)), .DEPTH(DIV_QW)) u_dly_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_data  (w_f1_sb),
        .o_data  (w_sb2)
    );

    // ---- hue wrap, saturation, lightness product
    logic [HUE_W-1:0]   w_hm;
    logic [HUE_W:0]     w_hs;
    logic [CH_BITS-1:0] w_sat;

    always_comb begin
        w_hm = w_q2[HUE_W-1:0];
        if (w_sb2.neg) begin
            if (w_hm > w_sb2.base)
                w_hs = {1'b0, w_sb2.base} + {1'b0, HUE_FULL} - {1'b0, w_hm};
            else
                w_hs = {1'b0, w_sb2.base} - {1'b0, w_hm};
        end else begin
            w_hs = {1'b0, w_sb2.base} + {1'b0, w_hm};
            if (w_hs >= {1'b0, HUE_FULL}) w_hs = w_hs - {1'b0, HUE_FULL};
        end
        if (w_q1 > DIV_QW'(CH_MAX)) w_sat = CH_MAX;
        else                        w_sat = w_q1[CH_BITS-1:0];
    end

    logic               r_f3_valid;
    logic [HUE_W-1:0]   r_f3_hue, r_f3_hin;
    logic [CH_BITS-1:0] r_f3_sat, r_f3_light, r_f3_sin, r_f3_lin, r_f3_alpha;
    logic [LP_W-1:0]    r_f3_lprod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_f3_valid <= 1'b0;
        else if (w_en) r_f3_valid <= w_sb2.valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f3_hue   <= w_sb2.grey ? '0 : w_hs[HUE_W-1:0];
            r_f3_sat   <= w_sb2.grey ? '0 : w_sat;
            r_f3_light <= w_sb2.light;
            r_f3_lprod <= LP_W'(w_sb2.light) * LP_W'(r_light_scale);
            r_f3_hin   <= w_sb2.hin;
            r_f3_sin   <= w_sb2.sin;
            r_f3_lin   <= w_sb2.lin;
            r_f3_alpha <= w_sb2.alpha;
        end
    end

    // ---- scaled lightness, choose HSL source for the inverse
    logic [LP_W:0]      w_lsum;
    logic [CH_BITS-1:0] w_l2;

    always_comb begin
        w_lsum = (LP_W+1)'(r_f3_lprod) + (LP_W+1)'(128);
        if (w_lsum[LP_W:8] > (LP_W-7)'(CH_MAX)) w_l2 = CH_MAX;
        else                                     w_l2 = w_lsum[CH_BITS+7:8];
    end

    logic               r_f4_valid;
    logic [HUE_W-1:0]   r_f4_ih;
    logic [CH_BITS-1:0] r_f4_is, r_f4_il;
    t_sb4               r_f4_sb;
    t_sb4               w_f4_sb, w_sb5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_f4_valid <= 1'b0;
        else if (w_en) r_f4_valid <= r_f3_valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_mode == MODE_HSL2RGB) begin
                r_f4_ih <= r_f3_hin;
                r_f4_is <= r_f3_sin;
                r_f4_il <= r_f3_lin;
            end else begin
                r_f4_ih <= r_f3_hue;
                r_f4_is <= r_f3_sat;
                r_f4_il <= w_l2;
            end
            r_f4_sb.valid <= r_f3_valid;
            r_f4_sb.hue   <= r_f3_hue;
            r_f4_sb.sat   <= r_f3_sat;
            r_f4_sb.light <= r_f3_light;
            r_f4_sb.alpha <= r_f3_alpha;
        end
    end

    always_comb begin
        w_f4_sb       = r_f4_sb;
        w_f4_sb.valid = r_f4_valid;
    end

    // ---- HSL to RGB
    logic [CH_BITS-1:0] w_red, w_green, w_blue;

    rhc_inv u_inv (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_hue   (r_f4_ih),
        .i_sat   (r_f4_is),
        .i_light (r_f4_il),
        .o_red   (w_red),
        .o_green (w_green),
        .o_blue  (w_blue)
    );

    rhc_delay #(.WIDTH($bits(t_sb4)), .DEPTH(INV_LAT)) u_dly_inv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_data  (w_f4_sb),
        .o_data  (w_sb5)
    );

    // ---- output register and skid word
    t_pix w_pix;
    t_pix r_o, r_sk;
    logic r_o_valid, r_sk_valid;

    always_comb begin
        w_pix       = '0;
        w_pix.alpha = w_sb5.alpha;
        unique case (r_mode) inside
            MODE_RGB2HSL: begin
                w_pix.hue   = w_sb5.hue;
                w_pix.sat   = w_sb5.sat;
                w_pix.light = w_sb5.light;
            end
            MODE_HSL2RGB, MODE_SCALE: begin
                w_pix.red   = w_red;
                w_pix.green = w_green;
                w_pix.blue  = w_blue;
            end
            default: ;
        endcase
    end

    // pipeline only holds while the skid word is occupied
    assign w_en    = !r_sk_valid;
    assign o_stall = r_sk_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid  <= 1'b0;
            r_sk_valid <= 1'b0;
        end else begin
            if (w_en) r_o_valid <= w_sb5.valid;
            if (w_en && r_o_valid && i_stall) r_sk_valid <= 1'b1;
            else if (r_sk_valid && !i_stall)  r_sk_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_o <= w_pix;
        if (w_en && r_o_valid && i_stall) r_sk <= r_o;
    end

    t_pix w_out;
    assign w_out            = r_sk_valid ? r_sk : r_o;
    assign o_valid          = r_sk_valid | r_o_valid;
    assign o_red_out        = w_out.red;
    assign o_green_out      = w_out.green;
    assign o_blue_out       = w_out.blue;
    assign o_hue_out        = w_out.hue;
    assign o_saturation_out = w_out.sat;
    assign o_lightness_out  = w_out.light;
    assign o_alpha_out      = w_out.alpha;

endmodule

/* verif/rgb_hsl_colour_converter_top_tb.sv */
`timescale 1ns / 1ps

module rgb_hsl_colour_converter_top_tb;
    import rhc_pkg::*;

    localparam logic [1:0]           MODE_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;
    localparam longint CHM        = (64'd1 << CH_BITS) - 1;
    localparam int     DRAIN_CYC  = 40;
    localparam int     HOLD_CYC   = 300;
    localparam int     WDOG_LIMIT = 3000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [CH_BITS-1:0]   i_red_in = '0, i_green_in = '0, i_blue_in = '0;
    logic [HUE_W-1:0]     i_hue_in = '0;
    logic [CH_BITS-1:0]   i_saturation_in = '0, i_lightness_in = '0, i_alpha_in = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [CH_BITS-1:0]   o_red_out, o_green_out, o_blue_out;
    logic [HUE_W-1:0]     o_hue_out;
    logic [CH_BITS-1:0]   o_saturation_out, o_lightness_out, o_alpha_out;

    rgb_hsl_colour_converter_top i_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_pix        pend_q[$];
    t_pix        pix_exp_q[$];
    t_pix        cur_pix;
    logic [1:0]  mode_r = MODE_RGB2HSL;
    logic [15:0] scale_r = LIGHT_SCALE_RESET;
    int          max_gap = 4, max_stall = 4;
    int          send_gap = 0, stall_left = 0, hold_left = 0;
    bit          hold_req = 0, hold_seen = 0, busy, stall_now;
    int          words_in = 0, words_out = 0, n_err = 0, idle_cyc = 0;

    function automatic longint rdiv(longint n, longint d);
        if (d == 0) return 0;
        return (n + d / 2) / d;
    endfunction

    function automatic void fwd_hsl(input longint r, g, b,
                                    output longint h, s, l);
        longint mx, mn, d, sum, den, num, base, mag;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        sum = mx + mn;
        l = sum >> 1;
        h = 0; s = 0;
        if (d == 0) return;
        den = (sum < CHM) ? sum : (2 * CHM - sum);
        s = rdiv(d * CHM, den);
        if (s > CHM) s = CHM;
        if (r == mx) begin
            base = 0; num = g - b;
        end else if (g == mx) begin
            base = HUE_THIRD; num = b - r;
        end else begin
            base = HUE_TWO_THIRDS; num = r - g;
        end
        mag = rdiv((num < 0 ? -num : num) * HUE_SIXTH, d);
        h = (num < 0) ? base - mag : base + mag;
        if (h < 0) h += HUE_FULL;
        if (h >= HUE_FULL) h -= HUE_FULL;
    endfunction

    function automatic longint hue_ramp(longint v1, v2, t);
        longint diff, x, q;
        diff = v2 - v1;
        if (t < HUE_SIXTH) x = t;
        else if (t < HUE_HALF) return v2;
        else if (t < HUE_TWO_THIRDS) x = HUE_TWO_THIRDS - t;
        else return v1;
        q = rdiv((diff < 0 ? -diff : diff) * x, HUE_SIXTH);
        return diff < 0 ? v1 - q : v1 + q;
    endfunction

    function automatic longint clamp_ch(longint v);
        if (v < 0) return 0;
        if (v > CHM) return CHM;
        return v;
    endfunction

    function automatic void inv_rgb(input longint h, s, l, output longint rgb[3]);
        longint v1, v2, ls, hv, t;
        if (s == 0) begin
            for (int k = 0; k < 3; k++) rgb[k] = clamp_ch(l);
            return;
        end
        ls = rdiv(l * s, CHM);
        v2 = (2 * l < CHM) ? l + ls : l + s - ls;
        v1 = 2 * l - v2;
        hv = h % HUE_FULL;
        for (int k = 0; k < 3; k++) begin
            t = hv + HUE_THIRD - k * HUE_THIRD;
            if (t < 0) t += HUE_FULL;
            if (t >= HUE_FULL) t -= HUE_FULL;
            rgb[k] = clamp_ch(hue_ramp(v1, v2, t));
        end
    endfunction

    function automatic t_pix convert_pixel(t_pix p);
        t_pix   o;
        longint h, s, l;
        longint rgb[3];
        o = '0;
        o.alpha = p.alpha;
        if (mode_r == MODE_RGB2HSL) begin
            fwd_hsl(p.red, p.green, p.blue, h, s, l);
            o.hue = h[HUE_W-1:0]; o.sat = s[15:0]; o.light = l[15:0];
        end else if (mode_r == MODE_HSL2RGB || mode_r == MODE_SCALE) begin
            if (mode_r == MODE_HSL2RGB) begin
                h = p.hue; s = p.sat; l = p.light;
            end else begin
                fwd_hsl(p.red, p.green, p.blue, h, s, l);
                l = (l * scale_r + 128) >> 8;
                if (l > CHM) l = CHM;
            end
            inv_rgb(h, s, l, rgb);
            o.red = rgb[0][15:0]; o.green = rgb[1][15:0]; o.blue = rgb[2][15:0];
        end
        return o;
    endfunction

    task automatic report_mismatch(string fld, longint got, longint want);
        n_err++;
        if (n_err <= 40)
            $display("mismatch word %0d %s: got %0d want %0d", words_out, fld, got, want);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
        end else begin
            busy = i_valid;
            if (i_valid && !o_stall) begin
                pix_exp_q.push_back(convert_pixel(cur_pix));
                words_in++;
                busy = 0;
                send_gap = $urandom_range(0, max_gap);
            end
            if (!busy) begin
                if (send_gap > 0) send_gap--;
                else if (pend_q.size() > 0) begin
                    cur_pix = pend_q.pop_front();
                    busy = 1;
                end
            end
            i_valid         <= busy;
            i_red_in        <= cur_pix.red;
            i_green_in      <= cur_pix.green;
            i_blue_in       <= cur_pix.blue;
            i_hue_in        <= cur_pix.hue;
            i_saturation_in <= cur_pix.sat;
            i_lightness_in  <= cur_pix.light;
            i_alpha_in      <= cur_pix.alpha;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_pix w;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pix_exp_q.size() == 0) begin
                    n_err++;
                    $display("unexpected word from converter");
                end else begin
                    w = pix_exp_q.pop_front();
                    if (o_red_out !== w.red) report_mismatch("red", o_red_out, w.red);
                    if (o_green_out !== w.green)
                        report_mismatch("green", o_green_out, w.green);
                    if (o_blue_out !== w.blue) report_mismatch("blue", o_blue_out, w.blue);
                    if (o_hue_out !== w.hue) report_mismatch("hue", o_hue_out, w.hue);
                    if (o_saturation_out !== w.sat)
                        report_mismatch("saturation", o_saturation_out, w.sat);
                    if (o_lightness_out !== w.light)
                        report_mismatch("lightness", o_lightness_out, w.light);
                    if (o_alpha_out !== w.alpha)
                        report_mismatch("alpha", o_alpha_out, w.alpha);
                end
                words_out++;
                stall_left = $urandom_range(0, max_stall);
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYC;
            end
            stall_now = (hold_left > 0) || (stall_left > 0);
            if (hold_left > 0) hold_left--;
            else if (stall_left > 0) stall_left--;
            i_stall <= stall_now;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cyc <= 0;
        else idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= WDOG_LIMIT) begin
            $display("watchdog: no progress, %0d words still due", pix_exp_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [15:0] rand_ch();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'(32767 + $urandom_range(0, 2));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_pix rand_pix();
        t_pix p;
        p.red = rand_ch(); p.green = rand_ch(); p.blue = rand_ch();
        // greys and ties now and then
        if ($urandom_range(0, 7) == 0) p.green = p.red;
        if ($urandom_range(0, 9) == 0) p.blue = p.red;
        p.hue = ($urandom_range(0, 5) == 0) ? HUE_W'($urandom) :
                HUE_W'($urandom_range(0, HUE_FULL - 1));
        p.sat = rand_ch(); p.light = rand_ch(); p.alpha = 16'($urandom);
        return p;
    endfunction

    function automatic t_pix mk(int r, g, b, h, s, l, a);
        t_pix p;
        p.red = 16'(r); p.green = 16'(g); p.blue = 16'(b); p.hue = HUE_W'(h);
        p.sat = 16'(s); p.light = 16'(l); p.alpha = 16'(a);
        return p;
    endfunction

    // sampled away from the active edge so the sender's updates have settled
    task automatic wait_idle();
        while (pend_q.size() > 0 || i_valid || pix_exp_q.size() > 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        if (idx == CFG_MODE) mode_r = val[1:0];
        else if (idx == CFG_LIGHT_SCALE) scale_r = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_directed();
        pend_q.push_back(mk(0, 0, 0, 0, 0, 0, 0));
        pend_q.push_back(mk(65535, 65535, 65535, 23040, 65535, 65535, 65535));
        pend_q.push_back(mk(65535, 0, 0, 0, 65535, 32767, 1));
        pend_q.push_back(mk(0, 65535, 0, 7680, 65535, 32768, 2));
        pend_q.push_back(mk(0, 0, 65535, 15360, 32768, 16384, 3));
        pend_q.push_back(mk(65535, 0, 65535, 32767, 1, 65535, 4));
        pend_q.push_back(mk(40000, 40000, 100, 3839, 65535, 1, 5));
        pend_q.push_back(mk(100, 200, 200, 11519, 40000, 50000, 6));
    endtask

    task automatic run_phase(logic [1:0] m, logic [15:0] sc, int n, bit burst);
        wait_idle();
        cfg_write(CFG_MODE, {14'd0, m});
        cfg_write(CFG_LIGHT_SCALE, sc);
        max_gap = burst ? 0 : 4;
        max_stall = burst ? 0 : 4;
        for (int i = 0; i < n; i++) pend_q.push_back(rand_pix());
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values in force: mode 0 first
        push_directed();
        wait_idle();
        cfg_write(CFG_MODE, {14'd0, MODE_HSL2RGB});
        push_directed();
        wait_idle();
        cfg_write(CFG_MODE, {14'd0, MODE_SCALE});
        push_directed();
        wait_idle();
        cfg_write(CFG_MODE, {14'd0, MODE_UNUSED});
        pend_q.push_back(mk(65535, 1, 2, 100, 65535, 30000, 16'hA5A5));
        wait_idle();
        // a mode write keeps only its low two bits; writes to indexes past the list must change nothing
        cfg_write(CFG_MODE, 16'hFFFE);
        cfg_write(CFG_UNUSED_A, 16'd1);
        cfg_write(CFG_UNUSED_B, 16'h0000);
        pend_q.push_back(mk(1, 2, 65535, 0, 0, 0, 16'h5A5A));

        run_phase(MODE_RGB2HSL, 16'd256, 80, 0);
        run_phase(MODE_HSL2RGB, 16'd256, 80, 1);
        run_phase(MODE_SCALE, 16'd0, 60, 0);
        run_phase(MODE_SCALE, 16'hFFFF, 60, 0);
        run_phase(MODE_SCALE, 16'd256, 60, 1);
        run_phase(MODE_SCALE, 16'(128 + $urandom_range(0, 300)), 80, 0);
        run_phase(MODE_HSL2RGB, 16'($urandom), 80, 0);
        run_phase(MODE_UNUSED, 16'($urandom), 30, 0);

        // long receiver hold while the sender keeps offering
        run_phase(MODE_SCALE, 16'(64 + $urandom_range(0, 1024)), 120, 1);
        hold_req = ~hold_req;
        wait_idle();
        run_phase(MODE_RGB2HSL, 16'($urandom), 80, 0);
        run_phase(MODE_SCALE, 16'(256 + $urandom_range(0, 512)), 80, 0);
        wait_idle();

        $display("words sent %0d, words checked %0d, mismatches %0d", words_in, words_out,
                 n_err);
        $display("covered all modes incl. unused, scale 0/1.0/max, bursts and long hold");
        if (n_err == 0 && pix_exp_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
